>>> rtl/premultiplied_pixel_blend_top_macros.svh
// Assertion macros for the pixel blend block
`ifndef PREMULTIPLIED_PIXEL_BLEND_TOP_MACROS_SVH
`define PREMULTIPLIED_PIXEL_BLEND_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PPB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ppb_pkg.sv
package ppb_pkg;
    localparam int unsigned ModeW = 5;
    localparam int unsigned ChW = 8;

    typedef enum logic [4:0] {
        M_DSTOVER = 5'd0, M_SRCIN = 5'd1, M_DSTIN = 5'd2, M_SRCOUT = 5'd3,
        M_DSTOUT = 5'd4, M_SRCATOP = 5'd5, M_DSTATOP = 5'd6, M_XOR = 5'd7,
        M_PLUS = 5'd8, M_MODULATE = 5'd9, M_SCREEN = 5'd10, M_OVERLAY = 5'd11,
        M_DARKEN = 5'd12, M_LIGHTEN = 5'd13, M_HARDLIGHT = 5'd14,
        M_DIFFERENCE = 5'd15, M_EXCLUSION = 5'd16, M_MULTIPLY = 5'd17
    } t_mode;

    localparam logic [1:0] RegBlendMode = 2'd0;

    // Product terms for one channel, registered after stage 1
    typedef struct packed {
        logic [15:0] p_sd;   // sc*da
        logic [15:0] p_ds;   // dc*sa
        logic [15:0] p_sc;   // sc*dc
        logic [15:0] p_sa;   // sa*da
        logic [15:0] p_sx;   // sc*(255-da)
        logic [15:0] p_dx;   // dc*(255-sa)
        logic [16:0] p_s1;   // sc*(da+1)
        logic [16:0] p_s2;   // sc*(256-da)
        logic [16:0] p_d1;   // dc*(sa+1)
        logic [16:0] p_d2;   // dc*(256-sa)
    } t_prod;

    // Rounded divide by 255 as the 16-bit wrapped form
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] a;
        logic [15:0] b;
        a = x + 16'd128;
        b = a + {8'd0, a[15:8]};
        return b[15:8];
    endfunction

    function automatic logic [7:0] clamp_div(input logic signed [19:0] v);
        if (v <= 20'sd0) return 8'd0;
        if (v >= 20'sd65025) return 8'd255;
        return div255(v[15:0]);
    endfunction
endpackage

>>> rtl/ppb_mul.sv
// Stage 1: all products of one channel
module ppb_mul (
    input  logic                 i_clk,
    input  logic [7:0]           i_sc,
    input  logic [7:0]           i_dc,
    input  logic [7:0]           i_sa,
    input  logic [7:0]           i_da,
    output ppb_pkg::t_prod       o_prod
);
    import ppb_pkg::*;
    t_prod n_prod;
    t_prod r_prod;

    always_comb begin
        n_prod.p_sd = i_sc * i_da;
        n_prod.p_ds = i_dc * i_sa;
        n_prod.p_sc = i_sc * i_dc;
        n_prod.p_sa = i_sa * i_da;
        n_prod.p_sx = i_sc * (8'd255 - i_da);
        n_prod.p_dx = i_dc * (8'd255 - i_sa);
        n_prod.p_s1 = {9'd0, i_sc} * ({9'd0, i_da} + 17'd1);
        n_prod.p_s2 = {9'd0, i_sc} * (17'd256 - {9'd0, i_da});
        n_prod.p_d1 = {9'd0, i_dc} * ({9'd0, i_sa} + 17'd1);
        n_prod.p_d2 = {9'd0, i_dc} * (17'd256 - {9'd0, i_sa});
    end

    // Hold products for the next stage
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end
    assign o_prod = r_prod;
endmodule

>>> rtl/ppb_comb.sv
// Stages 2 and 3: build the signed term, then divide, clamp and select
module ppb_comb (
    input  logic                 i_clk,
    input  logic                 i_alpha,
    input  logic [4:0]           i_mode,
    input  ppb_pkg::t_prod       i_prod,
    input  logic [7:0]           i_sc,
    input  logic [7:0]           i_dc,
    input  logic [7:0]           i_sa,
    input  logic [7:0]           i_da,
    output logic [7:0]           o_res
);
    import ppb_pkg::*;

    logic signed [19:0] n_v;
    logic               n_clamp;
    logic [7:0]         n_direct;
    logic [15:0]        n_da;
    logic [15:0]        n_db;
    logic [8:0]         n_base;
    logic [1:0]         n_op;
    logic signed [19:0] r_v;
    logic               r_clamp;
    logic [7:0]         r_direct;
    logic [15:0]        r_da;
    logic [15:0]        r_db;
    logic [8:0]         r_base;
    logic [1:0]         r_op;
    logic [7:0]         n_res;
    logic [7:0]         r_res;

    localparam logic [1:0] OpDirect = 2'd0;
    localparam logic [1:0] OpAdd2 = 2'd1;   // div(a)+div(b)
    localparam logic [1:0] OpSub1 = 2'd2;   // base-div(a)
    localparam logic [1:0] OpDiff = 2'd3;   // base-2*div(a), clamped when r_clamp is set

    // Stage 2: form the term for the chosen mode
    always_comb begin
        logic signed [19:0] com;
        logic signed [19:0] sub;
        logic               low;
        logic [8:0]         sum;
        com = 20'sd255 * $signed({11'd0, ({1'b0, i_sc} + {1'b0, i_dc})});
        sub = $signed({4'd0, i_prod.p_sd}) + $signed({4'd0, i_prod.p_ds})
            - $signed({3'd0, i_prod.p_sc, 1'b0});
        sum = {1'b0, i_sc} + {1'b0, i_dc};
        low = 1'b0;
        n_v = '0;
        n_clamp = 1'b0;
        n_direct = i_dc;
        n_da = '0;
        n_db = '0;
        n_base = '0;
        n_op = OpDirect;
        if (i_alpha && i_mode >= M_OVERLAY && i_mode <= M_MULTIPLY) begin
            n_op = OpSub1; n_base = sum; n_da = i_prod.p_sc;
        end else begin
            case (i_mode)
                M_DSTOVER: n_direct = i_dc + i_prod.p_s2[15:8];
                M_SRCIN: n_direct = i_prod.p_s1[15:8];
                M_DSTIN: n_direct = i_prod.p_d1[15:8];
                M_SRCOUT: n_direct = i_prod.p_s2[15:8];
                M_DSTOUT: n_direct = i_prod.p_d2[15:8];
                M_SRCATOP: begin
                    if (i_alpha) n_direct = i_da;
                    else begin n_op = OpAdd2; n_da = i_prod.p_sd; n_db = i_prod.p_dx; end
                end
                M_DSTATOP: begin
                    if (i_alpha) n_direct = i_sa;
                    else begin n_op = OpAdd2; n_da = i_prod.p_sx; n_db = i_prod.p_ds; end
                end
                M_XOR: begin
                    if (i_alpha) begin
                        n_op = OpDiff; n_base = sum; n_da = i_prod.p_sa;
                    end else begin
                        n_op = OpAdd2; n_da = i_prod.p_sx; n_db = i_prod.p_dx;
                    end
                end
                M_PLUS: n_direct = sum[8] ? 8'd255 : sum[7:0];
                M_MODULATE: begin n_op = OpAdd2; n_da = i_prod.p_sc; end
                M_SCREEN: begin n_op = OpSub1; n_base = sum; n_da = i_prod.p_sc; end
                M_OVERLAY, M_HARDLIGHT: begin
                    low = (i_mode == M_OVERLAY) ? ({i_dc, 1'b0} <= {1'b0, i_da})
                                                : ({i_sc, 1'b0} <= {1'b0, i_sa});
                    n_clamp = 1'b1;
                    n_v = low ? com - sub : com + sub - $signed({4'd0, i_prod.p_sa});
                end
                M_DARKEN, M_LIGHTEN: begin
                    n_op = OpSub1; n_base = sum;
                    if (i_mode == M_LIGHTEN)
                        n_da = (i_prod.p_sd > i_prod.p_ds) ? i_prod.p_ds : i_prod.p_sd;
                    else
                        n_da = (i_prod.p_sd < i_prod.p_ds) ? i_prod.p_ds : i_prod.p_sd;
                end
                M_DIFFERENCE: begin
                    n_op = OpDiff; n_base = sum; n_clamp = 1'b1;
                    n_da = (i_prod.p_sd < i_prod.p_ds) ? i_prod.p_sd : i_prod.p_ds;
                end
                M_EXCLUSION: begin
                    n_clamp = 1'b1;
                    n_v = com - $signed({3'd0, i_prod.p_sc, 1'b0});
                end
                M_MULTIPLY: begin
                    n_clamp = 1'b1;
                    n_v = $signed({4'd0, i_prod.p_sx}) + $signed({4'd0, i_prod.p_dx})
                        + $signed({4'd0, i_prod.p_sc});
                end
                default: n_direct = i_dc;
            endcase
        end
    end

    // Hold stage-2 terms
    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_clamp <= n_clamp;
        r_direct <= n_direct;
        r_da <= n_da;
        r_db <= n_db;
        r_base <= n_base;
        r_op <= n_op;
    end

    // Stage 3: round, clamp and pick the channel value
    always_comb begin
        logic [7:0]        qa;
        logic signed [10:0] d;
        qa = div255(r_da);
        d = $signed({2'b0, r_base}) - $signed({2'b0, qa, 1'b0});
        n_res = r_direct;
        if (r_op == OpAdd2) n_res = qa + div255(r_db);
        else if (r_op == OpSub1) n_res = r_base[7:0] - qa;
        else if (r_op == OpDiff) begin
            if (!r_clamp) n_res = d[7:0];
            else if (d < 0) n_res = 8'd0;
            else if (d > 11'sd255) n_res = 8'd255;
            else n_res = d[7:0];
        end else if (r_clamp) n_res = clamp_div(r_v);
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end
    assign o_res = r_res;
endmodule

>>> rtl/premultiplied_pixel_blend_top.sv
// Channel  | Handshake          | Payload
// input    | i_start / o_busy   | i_src_*, i_dst_* (8 bits each)
// result   | o_done strobe      | o_out_* (8 bits each)
// config   | APB psel/penable   | blend_mode at address 0
// One pixel enters each cycle; o_busy is always low.
// A pixel passes through products, term build, then rounding into the output register.
// The mode is sampled at entry and travels with the pixel.
// Reset (synchronous, active low) clears the valid bits and the mode.
// The receiver cannot stall, so nothing holds the pipeline.
module premultiplied_pixel_blend_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [7:0] i_src_alpha,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    input  logic [7:0] i_dst_alpha,
    input  logic [7:0] i_dst_red,
    input  logic [7:0] i_dst_green,
    input  logic [7:0] i_dst_blue,
    output logic       o_done,
    output logic [7:0] o_out_alpha,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import ppb_pkg::*;
`include "premultiplied_pixel_blend_top_macros.svh"

    logic [4:0]  r_mode;
    logic [2:0]  r_vld;
    logic [4:0]  r_mode1;
    logic [7:0]  r_s [4];
    logic [7:0]  r_d [4];
    logic [7:0]  w_s [4];
    logic [7:0]  w_d [4];
    logic [7:0]  w_res [4];
    t_prod       w_prod [4];
    logic        w_acc;

    assign o_busy = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr == RegBlendMode) ? {27'd0, r_mode} : 32'd0;
    assign w_acc = i_start && !o_busy;
    assign w_s[0] = i_src_alpha; assign w_s[1] = i_src_red;
    assign w_s[2] = i_src_green; assign w_s[3] = i_src_blue;
    assign w_d[0] = i_dst_alpha; assign w_d[1] = i_dst_red;
    assign w_d[2] = i_dst_green; assign w_d[3] = i_dst_blue;

    // Write the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= '0;
        else if (psel && penable && pwrite && paddr == RegBlendMode) r_mode <= pwdata[4:0];
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else r_vld <= {r_vld[1:0], w_acc};
    end

    // Carry pixel and mode alongside the products
    always_ff @(posedge i_clk) begin
        r_mode1 <= r_mode;
        r_s <= w_s;
        r_d <= w_d;
    end

    for (genvar g = 0; g < 4; g++) begin : g_ch
        ppb_mul u_mul (
            .i_clk(i_clk), .i_sc(w_s[g]), .i_dc(w_d[g]), .i_sa(w_s[0]), .i_da(w_d[0]),
            .o_prod(w_prod[g])
        );
        ppb_comb u_comb (
            .i_clk(i_clk), .i_alpha(g == 0), .i_mode(r_mode1), .i_prod(w_prod[g]),
            .i_sc(r_s[g]), .i_dc(r_d[g]), .i_sa(r_s[0]), .i_da(r_d[0]),
            .o_res(w_res[g])
        );
    end

    assign o_done = r_vld[2];
    assign o_out_alpha = w_res[0];
    assign o_out_red = w_res[1];
    assign o_out_green = w_res[2];
    assign o_out_blue = w_res[3];

    `PPB_ASSERT_NEXT(a_lat, i_clk, i_rst_n, w_acc, r_vld[0])
    `PPB_ASSERT_NEXT(a_done, i_clk, i_rst_n, r_vld[1], o_done)
    `PPB_ASSERT_IMPL(a_busy, i_clk, i_rst_n, i_start, !o_busy)
endmodule
